### src/efqm_pkg.sv
`default_nettype none
package efqm_pkg;

    localparam int STAT_N    = 6;
    localparam int C_MISS    = 0;
    localparam int C_EMPTY   = 1;
    localparam int C_MISS10  = 2;
    localparam int C_MISS50  = 3;
    localparam int C_EMPTY10 = 4;
    localparam int C_EMPTY50 = 5;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_SOURCE  = 1'b1;

    localparam logic [2:0] MODE_RESET = 3'b001;
    localparam int MODE_BASIC  = 0;
    localparam int MODE_FRAC   = 1;
    localparam int MODE_DETAIL = 2;

    // op queue between classifier and executor
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic              is_end;     // 1: event end, 0: histogram bump
        logic [3:0]        sid;
        logic [STAT_N-1:0] inc;        // stat counter bumps for this event
        logic              dump;       // per-source dump requested
        logic [7:0]        expected;
    } efqm_op_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] events_seen;
        logic [7:0]  expected_count;
        logic [31:0] with_missing;
        logic [31:0] with_empty;
        logic [31:0] missing_ten_pct;
        logic [31:0] missing_half;
        logic [31:0] empty_ten_pct;
        logic [31:0] empty_half;
        logic [3:0]  report_id;
        logic [31:0] report_count;
        logic        last;
    } efqm_res_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage
`default_nettype wire

### src/efqm_queue.sv
`default_nettype none
module efqm_queue
    import efqm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire efqm_op_t push_op,
    output logic          full,
    input  wire logic     pop,
    output efqm_op_t      head,
    output logic          empty
);

    efqm_op_t       mem_reg [QDEPTH];
    logic [QAW:0]   wr_ptr_reg;
    logic [QAW:0]   rd_ptr_reg;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[QAW] != rd_ptr_reg[QAW]) &&
                   (wr_ptr_reg[QAW-1:0] == rd_ptr_reg[QAW-1:0]);
    assign head  = mem_reg[rd_ptr_reg[QAW-1:0]];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg[QAW-1:0]] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### src/efqm_front.sv
`default_nettype none
module efqm_front
    import efqm_pkg::*;
#(
    parameter int MAX_FRAGMENTS = 255,
    parameter int HIST_DEPTH    = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       present,
    input  wire logic       is_empty,
    input  wire logic [3:0] source_id,
    input  wire logic       end_of_event,
    input  wire logic       cfg_valid,
    input  wire logic [2:0] cfg_data,
    output logic            push_valid,
    output efqm_op_t        push_op,
    input  wire logic       q_full
);

    localparam int CW = $clog2(MAX_FRAGMENTS + 1);

    logic [2:0]    mode_reg;
    logic [CW-1:0] total_reg, empties_reg, expected_reg;
    logic [CW-1:0] snap_total_reg, snap_empties_reg;
    logic          end_pend_reg;

    logic          accept;
    logic          hist_hit;
    logic [CW-1:0] total_next, empties_next, exp_next;

    // end-of-event classify
    logic [CW-1:0] missing;
    logic [CW+3:0] mis_w, emp_w, exp_w;
    logic [CW+3:0] mis10, mis2, emp10, emp2;
    logic [CW+7:0] exp_ext;
    logic          frac_ok;
    efqm_op_t      end_op, hist_op;

    assign in_ready = !end_pend_reg && !q_full;
    assign accept   = in_valid && in_ready;
    assign hist_hit = present && is_empty && ({1'b0, source_id} < 5'(HIST_DEPTH));

    always_comb
    begin
        total_next   = total_reg;
        empties_next = empties_reg;
        if (present && total_reg != CW'(MAX_FRAGMENTS))
        begin
            total_next = total_reg + 1'b1;
        end
        if (present && is_empty && empties_reg != CW'(MAX_FRAGMENTS))
        begin
            empties_next = empties_reg + 1'b1;
        end
        exp_next = (total_next > expected_reg) ? total_next : expected_reg;
    end

    always_comb
    begin
        missing = expected_reg - snap_total_reg;
        mis_w   = (CW+4)'(missing);
        emp_w   = (CW+4)'(snap_empties_reg);
        exp_w   = (CW+4)'(expected_reg);
        mis10   = (mis_w << 3) + (mis_w << 1);
        mis2    = mis_w << 1;
        emp10   = (emp_w << 3) + (emp_w << 1);
        emp2    = emp_w << 1;
        exp_ext = {8'd0, expected_reg};
        frac_ok = mode_reg[MODE_FRAC] && (expected_reg != '0);

        end_op                = '0;
        end_op.is_end         = 1'b1;
        end_op.inc[C_MISS]    = mode_reg[MODE_BASIC] && (missing != '0);
        end_op.inc[C_EMPTY]   = mode_reg[MODE_BASIC] && (snap_empties_reg != '0);
        end_op.inc[C_MISS10]  = frac_ok && (mis10 >= exp_w);
        end_op.inc[C_MISS50]  = frac_ok && (mis2 >= exp_w);
        end_op.inc[C_EMPTY10] = frac_ok && (emp10 >= exp_w);
        end_op.inc[C_EMPTY50] = frac_ok && (emp2 >= exp_w);
        end_op.dump           = mode_reg[MODE_DETAIL] && (snap_empties_reg != '0);
        end_op.expected       = exp_ext[7:0];

        hist_op        = '0;
        hist_op.sid    = source_id;

        push_op    = end_pend_reg ? end_op : hist_op;
        push_valid = end_pend_reg || (accept && hist_hit);
    end

    always_ff @(posedge clk)
    begin
        if (accept && end_of_event)
        begin
            snap_total_reg   <= total_next;
            snap_empties_reg <= empties_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RESET;
            total_reg    <= '0;
            empties_reg  <= '0;
            expected_reg <= '0;
            end_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (accept)
            begin
                if (end_of_event)
                begin
                    total_reg    <= '0;
                    empties_reg  <= '0;
                    expected_reg <= exp_next;
                    end_pend_reg <= 1'b1;
                end
                else
                begin
                    total_reg   <= total_next;
                    empties_reg <= empties_next;
                end
            end
            else if (end_pend_reg && !q_full)
            begin
                end_pend_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### src/efqm_back.sv
`default_nettype none
module efqm_back
    import efqm_pkg::*;
#(
    parameter int HIST_DEPTH = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire efqm_op_t q_head,
    input  wire logic     q_empty,
    output logic          q_pop,
    output logic          out_valid,
    input  wire logic     out_ready,
    output efqm_res_t     out_res
);

    localparam int IW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_WAIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // counters
    logic [31:0] events_reg;
    logic [31:0] stat_reg [STAT_N];
    logic [7:0]  expected_reg;
    logic        dump_reg;

    // histogram store, one entry per source
    logic [31:0]           hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] hist_vld_reg;
    logic [31:0]           rd_data_reg;
    logic                  rd_vld_reg;
    logic                  byp_reg;
    logic [31:0]           byp_data_reg;
    logic                  s1_valid_reg;
    logic [IW-1:0]         s1_addr_reg;

    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [31:0]           wr_data;
    logic [31:0]           old_val;
    logic [IW+3:0]         sid_w;
    logic [IW+3:0]         idx_w;

    logic [IW-1:0]         idx_reg, idx_next;
    logic                  any_vld;
    logic                  more_after;

    logic                  out_valid_reg;
    efqm_res_t             out_res_reg;
    logic                  out_free;
    logic                  load;
    efqm_res_t             load_res;

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign any_vld   = |hist_vld_reg;

    assign q_pop = (state_reg == ST_RUN) && !q_empty;
    assign sid_w = {{IW{1'b0}}, q_head.sid};
    assign idx_w = {4'd0, idx_reg};

    always_comb
    begin
        more_after = 1'b0;
        for (int j = 0; j < HIST_DEPTH; j++)
        begin
            if (j > int'(idx_reg) && hist_vld_reg[j])
            begin
                more_after = 1'b1;
            end
        end
    end

    // increment stage
    assign old_val = byp_reg ? byp_data_reg : (rd_vld_reg ? rd_data_reg : 32'd0);
    assign wr_en   = s1_valid_reg;
    assign wr_addr = s1_addr_reg;
    assign wr_data = sat_inc32(old_val);

    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = sid_w[IW-1:0];
        state_next = state_reg;
        idx_next   = idx_reg;
        load       = 1'b0;

        load_res                 = '0;
        load_res.kind            = KIND_SUMMARY;
        load_res.events_seen     = events_reg;
        load_res.expected_count  = expected_reg;
        load_res.with_missing    = stat_reg[C_MISS];
        load_res.with_empty      = stat_reg[C_EMPTY];
        load_res.missing_ten_pct = stat_reg[C_MISS10];
        load_res.missing_half    = stat_reg[C_MISS50];
        load_res.empty_ten_pct   = stat_reg[C_EMPTY10];
        load_res.empty_half      = stat_reg[C_EMPTY50];

        case (state_reg)
            ST_RUN:
            begin
                if (q_pop)
                begin
                    if (q_head.is_end)
                    begin
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                load_res.last = !(dump_reg && any_vld);
                if (out_free)
                begin
                    load     = 1'b1;
                    idx_next = '0;
                    state_next = (dump_reg && any_vld) ? ST_SCAN : ST_RUN;
                end
            end
            ST_SCAN:
            begin
                rd_addr = idx_reg;
                if (hist_vld_reg[idx_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                load_res.kind         = KIND_SOURCE;
                load_res.report_id    = idx_w[3:0];
                load_res.report_count = rd_data_reg;
                load_res.last         = !more_after;
                if (out_free)
                begin
                    load = 1'b1;
                    if (more_after)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= hist_mem[rd_addr];
            rd_vld_reg   <= hist_vld_reg[rd_addr];
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
        s1_addr_reg <= rd_addr;
        if (load)
        begin
            out_res_reg <= load_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            hist_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
            events_reg    <= '0;
            expected_reg  <= '0;
            dump_reg      <= 1'b0;
            for (int k = 0; k < STAT_N; k++)
            begin
                stat_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            s1_valid_reg <= q_pop && !q_head.is_end;
            if (wr_en)
            begin
                hist_vld_reg[wr_addr] <= 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop && q_head.is_end)
            begin
                events_reg   <= sat_inc32(events_reg);
                expected_reg <= q_head.expected;
                dump_reg     <= q_head.dump;
                for (int k = 0; k < STAT_N; k++)
                begin
                    if (q_head.inc[k])
                    begin
                        stat_reg[k] <= sat_inc32(stat_reg[k]);
                    end
                end
            end
        end
    end

    // a dump never overlaps a pending histogram increment
    a_no_incr_outside_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> !s1_valid_reg)
        else $error("histogram increment in flight outside run state");

    a_scan_has_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_WAIT) |-> any_vld)
        else $error("per-source scan with empty histogram");

    a_source_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.kind == KIND_SOURCE) |-> (out_res_reg.report_count != 0))
        else $error("per-source word with zero count");

    a_wait_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && $past(state_reg) == ST_SCAN) |-> $past(rd_en))
        else $error("scan word without histogram read");

endmodule
`default_nettype wire

### src/event_fragment_quality_monitor_core.sv
`default_nettype none
// Fragment quality monitor. Takes one fragment record per word on the slave
// stream and keeps event statistics: the largest per-event fragment total is
// the expected count, and each event end advances the saturating counters
// picked by mode_mask (bit0 any-missing/any-empty, bit1 10%/50% fractions,
// bit2 per-source empty dump). Every event end gives a summary word on the
// master stream (tuser 0); in detailed mode an event with empties is followed
// by one word per source ID with a nonzero empty count since reset (tuser 1),
// ID order, tlast on the final word of the event. Fragment words go in at one
// per cycle while the op queue has room; after the word with tlast, input is
// held until the classifier has pushed its end op. The executor bumps one
// histogram entry per cycle while it runs, loads the summary word, and writes
// out each source word by a histogram read, then an output load, stepping
// over histogram entries with no count, so a long dump backs up the 4-entry op
// queue and then stalls input. No clearing pass after reset: the histogram
// carries one valid bit per entry.
module event_fragment_quality_monitor_core
    import efqm_pkg::*;
#(
    parameter int SOURCE_IDS    = 16,
    parameter int MAX_FRAGMENTS = 255
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [3:0] source_id, rest zero
    input  wire logic [1:0]   s_axis_tuser,   // [0] present, [1] is_empty
    input  wire logic         s_axis_tlast,   // end_of_event

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] events_seen, [39:32] expected_count, [71:40] with_missing,
    // [103:72] with_empty, [135:104] missing_ten_pct, [167:136] missing_half,
    // [199:168] empty_ten_pct, [231:200] empty_half, [235:232] report_id,
    // [267:236] report_count, [271:268] zero
    output logic [271:0]      m_axis_tdata,
    output logic [0:0]        m_axis_tuser,   // [0] kind
    output logic              m_axis_tlast,   // last word of the event

    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_data        // mode_mask
);

    // only source IDs 0..15 fit the 4-bit field
    localparam int HIST_DEPTH = (SOURCE_IDS < 16) ? SOURCE_IDS : 16;

    efqm_op_t  push_op, q_head;
    logic      push_valid, q_full, q_empty, q_pop;
    efqm_res_t res;

    assign cfg_ready = 1'b1;

    efqm_front #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .HIST_DEPTH    (HIST_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .present      (s_axis_tuser[0]),
        .is_empty     (s_axis_tuser[1]),
        .source_id    (s_axis_tdata[3:0]),
        .end_of_event (s_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .push_valid   (push_valid),
        .push_op      (push_op),
        .q_full       (q_full)
    );

    efqm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push_valid),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty)
    );

    efqm_back #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {4'd0, res.report_count, res.report_id, res.empty_half,
                           res.empty_ten_pct, res.missing_half, res.missing_ten_pct,
                           res.with_empty, res.with_missing, res.expected_count,
                           res.events_seen};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
`default_nettype wire
